FILE: hdl/deadband_history_logger_core_assert.svh
// Assertion macros shared by the deadband history logger RTL
`ifndef DEADBAND_HISTORY_LOGGER_CORE_ASSERT_SVH
`define DEADBAND_HISTORY_LOGGER_CORE_ASSERT_SVH

// Clocked check, masked while reset is asserted
`define DBHL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define DBHL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/dbhl_pkg.sv
// Types and constants of the deadband history logger
`timescale 1ns / 1ps

package dbhl_pkg;

  localparam int unsigned UNIT_W = 11;
  localparam logic [6:0] THRESHOLD_RESET = 7'd5;

  typedef enum logic [1:0] {
    KIND_CHANGE = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADDMOD  = 2'd0,
    OP_ABSDIFF = 2'd1,
    OP_LT      = 2'd2
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHECK,
    S_IDXADDR,
    S_NEWEST,
    S_FETCH,
    S_USE,
    S_COMPARE,
    S_TAIL,
    S_WRITE,
    S_BUMP,
    S_FINISH
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  charge_percent;
    logic [31:0] timestamp_seconds;
    logic [4:0]  read_index;
  } in_t;

  typedef struct packed {
    logic        recorded;
    logic [5:0]  entry_count;
    logic        read_valid;
    logic [31:0] read_timestamp;
    logic [6:0]  read_percent;
  } out_t;

  typedef struct packed {
    logic [31:0] ts;
    logic [6:0]  pct;
  } entry_t;

  typedef struct packed {
    alu_op_t           op;
    logic [UNIT_W-1:0] a;
    logic [UNIT_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [UNIT_W-1:0] res;
    logic              lt;
  } alu_rsp_t;

endpackage

FILE: hdl/dbhl_shared_alu.sv
// Shared arithmetic unit: modular pointer add, absolute difference, less-than
`timescale 1ns / 1ps

module dbhl_shared_alu #(
  parameter int unsigned DEPTH = 32
) (
  input  dbhl_pkg::alu_req_t req,
  output dbhl_pkg::alu_rsp_t rsp
);

  localparam int unsigned SW = dbhl_pkg::UNIT_W + 1;

  logic [SW-1:0] sum;
  logic [SW-1:0] wrapped;

  always_comb begin
    sum     = SW'(req.a) + SW'(req.b);
    wrapped = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
    rsp.lt  = (req.a < req.b);
    case (req.op)
      dbhl_pkg::OP_ADDMOD:  rsp.res = wrapped[dbhl_pkg::UNIT_W-1:0];
      dbhl_pkg::OP_ABSDIFF: rsp.res = rsp.lt ? (req.b - req.a) : (req.a - req.b);
      default:              rsp.res = '0;
    endcase
  end

endmodule

FILE: hdl/deadband_history_logger_core.sv
// Top level of the deadband history logger: sequencer, log memory and result register
`timescale 1ns / 1ps
`include "deadband_history_logger_core_assert.svh"

// Deadband history logger.
// Input channel in_valid/in_ready/in_data carries one transaction per item: a change
// event, a periodic sample, a clear or a read. Every item yields exactly one result
// transaction on out_valid/out_ready/out_data, in order.
// The log is a circular buffer of DEPTH entries in a single-port memory with a head
// pointer and a fill count; an append on a full log overwrites the oldest entry and
// advances the head. A change event is appended when the log is empty or when its
// charge differs from the newest entry by at least the threshold.
// cfg_valid/cfg_ready/cfg_data writes the change threshold; cfg_ready is always high.
// The sequencer steps one shared add/compare unit and waits on the registered memory
// read: a clear goes straight to the result; a sample, or a change on an empty log,
// writes at the tail, with a head bump when full; a change first reads and compares
// the newest entry; a read checks its index against the count before it fetches.
// in_ready is high only in the idle state, so no new item is taken until the last result is registered.
// If the receiver stalls, the result waits in the output register; the next item is
// still accepted and processed, and its result waits until the register drains.
// Reset empties the log at once (fill count and head cleared, memory left as it is)
// and sets the threshold to 5.
module deadband_history_logger_core #(
  parameter int unsigned DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dbhl_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output dbhl_pkg::out_t   out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [6:0]       cfg_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned EW    = CW + 6;
  localparam int unsigned UW    = dbhl_pkg::UNIT_W;

  dbhl_pkg::state_t   state_r, state_nxt;
  dbhl_pkg::in_t      item_r, item_nxt;
  dbhl_pkg::entry_t   mem [DEPTH];
  dbhl_pkg::entry_t   rd_data_r;
  dbhl_pkg::out_t     out_data_r, out_data_nxt;
  dbhl_pkg::alu_req_t alu_req;
  dbhl_pkg::alu_rsp_t alu_rsp;

  logic [CW-1:0]    count_r, count_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] addr_r, addr_nxt;
  logic [6:0]       thr_r, thr_nxt;
  logic [6:0]       diff_r, diff_nxt;
  logic             rec_r, rec_nxt;
  logic             rvalid_r, rvalid_nxt;
  logic [31:0]      rts_r, rts_nxt;
  logic [6:0]       rpct_r, rpct_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             mem_we;
  logic             full;
  logic             out_free;
  logic [EW-1:0]    count_wide;

  dbhl_shared_alu #(.DEPTH(DEPTH)) u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign full       = (count_r == CW'(DEPTH));
  assign out_free   = !out_valid_r || out_ready;
  assign count_wide = EW'(count_r);
  assign in_ready   = (state_r == dbhl_pkg::S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // Next state of the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dbhl_pkg::S_IDLE: begin
        if (in_valid) state_nxt = dbhl_pkg::S_DISPATCH;
      end
      dbhl_pkg::S_DISPATCH: begin
        case (item_r.kind)
          dbhl_pkg::KIND_CHANGE: begin
            state_nxt = (count_r == '0) ? dbhl_pkg::S_TAIL : dbhl_pkg::S_NEWEST;
          end
          dbhl_pkg::KIND_SAMPLE: state_nxt = dbhl_pkg::S_TAIL;
          dbhl_pkg::KIND_CLEAR:  state_nxt = dbhl_pkg::S_FINISH;
          default:               state_nxt = dbhl_pkg::S_CHECK;
        endcase
      end
      dbhl_pkg::S_CHECK:   state_nxt = alu_rsp.lt ? dbhl_pkg::S_IDXADDR : dbhl_pkg::S_FINISH;
      dbhl_pkg::S_IDXADDR: state_nxt = dbhl_pkg::S_FETCH;
      dbhl_pkg::S_NEWEST:  state_nxt = dbhl_pkg::S_FETCH;
      dbhl_pkg::S_FETCH:   state_nxt = dbhl_pkg::S_USE;
      dbhl_pkg::S_USE: begin
        state_nxt = (item_r.kind == dbhl_pkg::KIND_READ) ? dbhl_pkg::S_FINISH
                                                          : dbhl_pkg::S_COMPARE;
      end
      dbhl_pkg::S_COMPARE: state_nxt = alu_rsp.lt ? dbhl_pkg::S_FINISH : dbhl_pkg::S_TAIL;
      dbhl_pkg::S_TAIL:    state_nxt = dbhl_pkg::S_WRITE;
      dbhl_pkg::S_WRITE:   state_nxt = full ? dbhl_pkg::S_BUMP : dbhl_pkg::S_FINISH;
      dbhl_pkg::S_BUMP:    state_nxt = dbhl_pkg::S_FINISH;
      dbhl_pkg::S_FINISH: begin
        if (out_free) state_nxt = dbhl_pkg::S_IDLE;
      end
      default:             state_nxt = dbhl_pkg::S_IDLE;
    endcase
  end

  // Datapath controls and register updates per state
  always_comb begin
    item_nxt      = item_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    addr_nxt      = addr_r;
    diff_nxt      = diff_r;
    rec_nxt       = rec_r;
    rvalid_nxt    = rvalid_r;
    rts_nxt       = rts_r;
    rpct_nxt      = rpct_r;
    thr_nxt       = cfg_valid ? cfg_data : thr_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    alu_req.op    = dbhl_pkg::OP_ADDMOD;
    alu_req.a     = '0;
    alu_req.b     = '0;
    case (state_r)
      dbhl_pkg::S_IDLE: begin
        if (in_valid) item_nxt = in_data;
      end
      dbhl_pkg::S_DISPATCH: begin
        rec_nxt    = 1'b0;
        rvalid_nxt = 1'b0;
        rts_nxt    = '0;
        rpct_nxt   = '0;
        if (item_r.kind == dbhl_pkg::KIND_CLEAR) count_nxt = '0;
      end
      dbhl_pkg::S_CHECK: begin
        // read index against the fill count
        alu_req.op = dbhl_pkg::OP_LT;
        alu_req.a  = UW'(item_r.read_index);
        alu_req.b  = UW'(count_r);
      end
      dbhl_pkg::S_IDXADDR: begin
        alu_req.a = UW'(head_r);
        alu_req.b = UW'(item_r.read_index);
        addr_nxt  = alu_rsp.res[PTR_W-1:0];
      end
      dbhl_pkg::S_NEWEST: begin
        alu_req.a = UW'(head_r);
        alu_req.b = UW'(count_r - CW'(1));
        addr_nxt  = alu_rsp.res[PTR_W-1:0];
      end
      dbhl_pkg::S_USE: begin
        if (item_r.kind == dbhl_pkg::KIND_READ) begin
          rvalid_nxt = 1'b1;
          rts_nxt    = rd_data_r.ts;
          rpct_nxt   = rd_data_r.pct;
        end else begin
          alu_req.op = dbhl_pkg::OP_ABSDIFF;
          alu_req.a  = UW'(item_r.charge_percent);
          alu_req.b  = UW'(rd_data_r.pct);
          diff_nxt   = alu_rsp.res[6:0];
        end
      end
      dbhl_pkg::S_COMPARE: begin
        alu_req.op = dbhl_pkg::OP_LT;
        alu_req.a  = UW'(diff_r);
        alu_req.b  = UW'(thr_r);
      end
      dbhl_pkg::S_TAIL: begin
        // on a full log this lands on the head, i.e. the oldest entry
        alu_req.a = UW'(head_r);
        alu_req.b = UW'(count_r);
        addr_nxt  = alu_rsp.res[PTR_W-1:0];
      end
      dbhl_pkg::S_WRITE: begin
        mem_we  = 1'b1;
        rec_nxt = 1'b1;
        if (!full) count_nxt = count_r + CW'(1);
      end
      dbhl_pkg::S_BUMP: begin
        alu_req.a = UW'(head_r);
        alu_req.b = UW'(1);
        head_nxt  = alu_rsp.res[PTR_W-1:0];
      end
      dbhl_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.recorded       = rec_r;
          out_data_nxt.entry_count    = count_wide[5:0];
          out_data_nxt.read_valid     = rvalid_r;
          out_data_nxt.read_timestamp = rts_r;
          out_data_nxt.read_percent   = rpct_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dbhl_pkg::S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      thr_r       <= dbhl_pkg::THRESHOLD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    addr_r     <= addr_nxt;
    diff_r     <= diff_nxt;
    rec_r      <= rec_nxt;
    rvalid_r   <= rvalid_nxt;
    rts_r      <= rts_nxt;
    rpct_r     <= rpct_nxt;
    out_data_r <= out_data_nxt;
  end

  // Log memory: one write or read address per cycle, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= '{ts: item_r.timestamp_seconds, pct: item_r.charge_percent};
    end
    rd_data_r <= mem[addr_r];
  end

  `DBHL_ASSERT_ALWAYS(a_count_bound, (!rst_n || count_r <= CW'(DEPTH)),
                      "fill count above depth")
  `DBHL_ASSERT_ALWAYS(a_head_bound, (!rst_n || 32'(head_r) < DEPTH),
                      "head pointer out of range")
  `DBHL_ASSERT(a_accept_dispatch,
               (in_valid && in_ready) |=> (state_r == dbhl_pkg::S_DISPATCH),
               "accepted transaction not dispatched")
  `DBHL_ASSERT(a_clear_empties,
               (state_r == dbhl_pkg::S_DISPATCH && item_r.kind == dbhl_pkg::KIND_CLEAR)
               |=> (count_r == '0),
               "clear left entries")
  `DBHL_ASSERT(a_finish_emits, (state_r == dbhl_pkg::S_FINISH && out_free) |=> out_valid_r,
               "result not presented")

endmodule
